[rtl/ghmi_pkg.sv]
// Shared constants, types and the exp table for the gaussian hit-or-miss integrator.
package ghmi_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int COUNTER_WIDTH = 32;
   localparam int EXP_DEPTH     = 256;
   localparam int EXP_IDX_BITS  = $clog2(EXP_DEPTH);
   // the table covers t (Q.16) in [0,16): index is t >> EXP_SHIFT, fraction the low bits
   localparam int EXP_SHIFT     = FRACTION_BITS + 4 - EXP_IDX_BITS;
   localparam int T_BITS        = 24;
   localparam int BOUND_BITS    = 21;
   localparam int MUL_BITS      = 34;
   localparam int DIV_STEPS     = 33;
   localparam longint unsigned F0_Q32 = 64'd1713444047;
   // table step 16/EXP_DEPTH in Q0.32
   localparam longint unsigned EXP_STEP_Q32 = (64'd16 << 32) / EXP_DEPTH;

   localparam logic [7:0] CSR_LOWER = 8'd0;
   localparam logic [7:0] CSR_UPPER = 8'd1;

   typedef logic [16:0] exp_tab_type [0:EXP_DEPTH];

   typedef struct packed {
      logic load_in;
      logic mul_p;
      logic calc_x;
      logic mul_t;
      logic mul_e;
      logic update;
      logic div_init;
      logic div_step;
      logic mul_a1;
      logic mul_a2;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic final_sample;
      logic out_busy;
   } stat_type;

   // shift-subtract quotient, used only while the table is elaborated
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type     tab;
      longint unsigned hq;
      longint unsigned term;
      longint unsigned r;
      longint unsigned v;
      longint          sum;
      hq   = EXP_STEP_Q32;
      term = 64'd1 << 32;
      sum  = longint'(term);
      for (int n = 1; n <= 24; n++) begin
         term = div_u64((term * hq) >> 32, 64'(n));
         if ((n & 1) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      r = longint'(sum);
      v = 64'd1 << 32;
      for (int k = 0; k <= EXP_DEPTH; k++) begin
         if (k > 0) v = (v * r + 64'h8000_0000) >> 32;
         tab[k] = 17'((v + 64'h8000) >> 16);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

[rtl/gaussian_hit_or_miss_integrator_top.sv]
// Top level of the gaussian hit-or-miss integrator.
// Use: write lower bound (index 0) and upper bound (index 1), Q.16 signed, on the
// csr channel while idle; csr_ready is always high. Each req beat carries
// uniform_x in tdata[15:0], uniform_y in tdata[31:16] and final_sample on tlast.
// The next beat is taken only when a sample is done; the shared multiplier
// serves three dependent products of a sample in turn and holds the next beat back.
// A beat with tlast also runs the divider (a load step, then 33 quotient
// steps) for hits/samples and two more multiplies; then the rsp beat shows
// tdata[20:0] area_estimate, [52:21] hits_total, [84:53] samples_total. The next
// req beat can be taken in the same cycle as the rsp beat first shows.
// The result sits in an output register; samples of the next run are taken
// while it waits. If the receiver still stalls when the next estimate is
// ready, the block waits and takes no req beat until the old beat is taken.
// Synchronous reset clears both counters, the output beat, and sets the
// bounds to 0 and 1.0.
module gaussian_hit_or_miss_integrator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // uniform_x, uniform_y
   input  logic        req_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [20:0] csr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // area_estimate, hits_total, samples_total, pad
);

   ghmi_pkg::cmd_type  cmd;
   ghmi_pkg::stat_type stat;

   ghmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ghmi_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/ghmi_ctrl.sv]
// Sequencer for one sample: multiplies, exp lookup, counter update, estimate.
module ghmi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ghmi_pkg::stat_type stat,
   output ghmi_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_P    = 4'd1;
   localparam logic [3:0] S_X    = 4'd2;
   localparam logic [3:0] S_T    = 4'd3;
   localparam logic [3:0] S_E    = 4'd4;
   localparam logic [3:0] S_HIT  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_A1   = 4'd7;
   localparam logic [3:0] S_A2   = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_P;
            end
         end
         S_P: begin
            cmd.mul_p = 1'b1;
            state_in  = S_X;
         end
         S_X: begin
            cmd.calc_x = 1'b1;
            state_in   = S_T;
         end
         S_T: begin
            cmd.mul_t = 1'b1;
            state_in  = S_E;
         end
         S_E: begin
            cmd.mul_e = 1'b1;
            state_in  = S_HIT;
         end
         S_HIT: begin
            cmd.update = 1'b1;
            if (stat.final_sample) begin
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (cnt_ff == 6'd0) begin
               cmd.div_init = 1'b1;
               cnt_in       = 6'd1;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == 6'(ghmi_pkg::DIV_STEPS)) begin
                  cnt_in   = 6'd0;
                  state_in = S_A1;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         S_A1: begin
            cmd.mul_a1 = 1'b1;
            state_in   = S_A2;
         end
         S_A2: begin
            cmd.mul_a2 = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/ghmi_datapath.sv]
// Datapath: bounds, shared multiplier, exp interpolation, counters, divider, result beat.
module ghmi_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ghmi_pkg::cmd_type  cmd,
   output ghmi_pkg::stat_type stat,
   input  logic [31:0]        req_tdata,
   input  logic               req_tlast,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [20:0]        csr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [87:0]        rsp_tdata
);

   localparam int MW = ghmi_pkg::MUL_BITS;
   localparam int CW = ghmi_pkg::COUNTER_WIDTH;

   logic signed [20:0] lower_ff, upper_ff;
   logic [15:0]        ux_ff, uy_ff;
   logic               fin_ff;
   logic signed [2*MW-1:0] prod_ff;
   logic signed [21:0] x_ff;
   logic [16:0]        ea_ff;
   logic               ezero_ff;
   logic [CW-1:0]      hit_ff, sample_ff;
   logic [32:0]        rem_ff, quo_ff;
   logic               out_valid_ff;
   logic [87:0]        out_data_ff;

   logic signed [21:0]   range_w;
   logic [21:0]          mag_w;
   logic signed [MW-1:0] op_a, op_b;
   logic                 mul_en;

   assign csr_ready = 1'b1;
   assign range_w   = 22'(upper_ff) - 22'(lower_ff);
   assign mag_w     = range_w[21] ? 22'(-range_w) : 22'(range_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= 21'sd0;
         upper_ff <= 21'sd65536;
      end else if (csr_valid) begin
         if (csr_index == ghmi_pkg::CSR_LOWER) lower_ff <= csr_data;
         else if (csr_index == ghmi_pkg::CSR_UPPER) upper_ff <= csr_data;
      end
   end

   // x = lower + p/65535 by folding 16-bit digits; floor for p >= 0, ceil-magnitude below
   logic signed [38:0] p_w;
   logic               p_neg;
   logic [37:0]        m_w;
   logic [21:0]        q0_w;
   logic [22:0]        r0_w;
   logic [6:0]         q1_w;
   logic [16:0]        r1_w;
   logic [21:0]        quo_w;
   logic signed [21:0] x_in;

   always_comb begin
      p_w   = prod_ff[38:0];
      p_neg = p_w[38];
      m_w   = p_neg ? 38'(-p_w) + 38'd65534 : 38'(p_w);
      q0_w  = m_w[37:16];
      r0_w  = 23'(m_w[15:0]) + 23'(q0_w);
      q1_w  = r0_w[22:16];
      r1_w  = 17'(r0_w[15:0]) + 17'(q1_w);
      quo_w = q0_w + 22'(q1_w) + 22'(r1_w >= 17'd65535);
      x_in  = 22'(lower_ff) + (p_neg ? 22'(-quo_w) : 22'(quo_w));
   end

   // exp table lookup from t = x*x >> 17
   logic [20:0]                  ax_w;
   logic [ghmi_pkg::T_BITS-1:0]  t_w;
   logic [ghmi_pkg::T_BITS-ghmi_pkg::EXP_SHIFT-1:0] tidx_w;
   logic [ghmi_pkg::EXP_SHIFT-1:0] tfrac_w;
   logic [ghmi_pkg::EXP_IDX_BITS:0] idx_w, idx1_w;
   logic [16:0]                  tab_a, tab_b;

   always_comb begin
      ax_w    = x_ff[21] ? 21'(-x_ff) : 21'(x_ff);
      t_w     = prod_ff[ghmi_pkg::T_BITS+16:17];
      tidx_w  = t_w[ghmi_pkg::T_BITS-1:ghmi_pkg::EXP_SHIFT];
      tfrac_w = t_w[ghmi_pkg::EXP_SHIFT-1:0];
      idx_w   = {1'b0, tidx_w[ghmi_pkg::EXP_IDX_BITS-1:0]};
      idx1_w  = idx_w + 1'b1;
      tab_a   = ghmi_pkg::EXP_TAB[idx_w];
      tab_b   = ghmi_pkg::EXP_TAB[idx1_w];
   end

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      mul_en = 1'b1;
      if (cmd.mul_p) begin
         op_a = MW'(range_w);
         op_b = MW'({1'b0, ux_ff});
      end else if (cmd.mul_t) begin
         op_a = MW'({1'b0, ax_w});
         op_b = MW'({1'b0, ax_w});
      end else if (cmd.mul_e) begin
         op_a = MW'({1'b0, tab_a - tab_b});
         op_b = MW'({1'b0, tfrac_w});
      end else if (cmd.mul_a1) begin
         op_a = MW'({1'b0, mag_w});
         op_b = MW'(ghmi_pkg::F0_Q32);
      end else if (cmd.mul_a2) begin
         op_a = MW'({1'b0, prod_ff[52:24]});
         op_b = MW'({1'b0, quo_ff});
      end else begin
         mul_en = 1'b0;
      end
   end

   // interpolated exp and hit test
   logic [16:0] e_w;
   logic [32:0] lhs_w, rhs_w;
   logic        hit_w;

   always_comb begin
      e_w   = ezero_ff ? 17'd0 : ea_ff - 17'(prod_ff[2*MW-1:ghmi_pkg::EXP_SHIFT]);
      lhs_w = {1'b0, uy_ff, 16'd0};
      rhs_w = {e_w, 16'd0} - 33'(e_w);
      hit_w = (lhs_w <= rhs_w);
   end

   logic [32:0] div_trial;
   logic        div_bit;
   assign div_bit   = (rem_ff >= 33'(sample_ff));
   assign div_trial = div_bit ? rem_ff - 33'(sample_ff) : rem_ff;

   logic [22:0] area_mag_w;
   logic [20:0] area_w;
   assign area_mag_w = 23'((prod_ff + (68'sd1 <<< 39)) >>> 40);
   assign area_w     = range_w[21] ? 21'(-area_mag_w) : 21'(area_mag_w);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ux_ff  <= req_tdata[15:0];
         uy_ff  <= req_tdata[31:16];
         fin_ff <= req_tlast;
      end
      if (mul_en) prod_ff <= op_a * op_b;
      if (cmd.calc_x) x_ff <= x_in;
      if (cmd.mul_e) begin
         ea_ff    <= tab_a;
         ezero_ff <= (tidx_w >= (ghmi_pkg::T_BITS - ghmi_pkg::EXP_SHIFT)'(ghmi_pkg::EXP_DEPTH));
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, hit_ff};
         quo_ff <= 33'd0;
      end else if (cmd.div_step) begin
         rem_ff <= {div_trial[31:0], 1'b0};
         quo_ff <= {quo_ff[31:0], div_bit};
      end
      if (cmd.load_out) out_data_ff <= {3'd0, sample_ff, hit_ff, area_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= '0;
         sample_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            hit_ff    <= '0;
            sample_ff <= '0;
         end else if (cmd.update) begin
            if (sample_ff != '1) sample_ff <= sample_ff + 1'b1;
            if (hit_w && hit_ff != '1) hit_ff <= hit_ff + 1'b1;
         end
         if (cmd.load_out) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata         = out_data_ff;
   assign stat.final_sample = fin_ff;
   assign stat.out_busy     = out_valid_ff;

`ifndef NO_ASSERTIONS
   a_hits_le_samples: assert property (@(posedge clock) disable iff (reset)
      hit_ff <= sample_ff) else $error("hit count exceeds sample count");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !out_valid_ff) else $error("result overwritten");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid) else $error("result beat not shown");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (sample_ff == '0 && !rsp_tvalid)) else $error("reset did not clear");
`endif

endmodule

[tb/gaussian_hit_or_miss_integrator_top_tb.sv]
// Self-checking testbench for the gaussian hit-or-miss integrator top level.
`timescale 1ns / 100ps

module gaussian_hit_or_miss_integrator_top_tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // uniform_x, uniform_y
   logic        req_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [20:0] csr_data;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;    // area_estimate, hits_total, samples_total, pad

   typedef struct packed {
      logic [20:0] area;
      logic [31:0] hits;
      logic [31:0] samples;
   } estimate_type;

   estimate_type estimate_q[$];
   int          error_count;
   int          estimates_seen;
   int          samples_sent;
   int          burst_left;
   int          stall_mode;

   // predictor state
   longint      lower_q16;
   longint      upper_q16;
   longint unsigned hit_count;
   longint unsigned sample_count;
   logic [31:0] exp_points [0:256];

   gaussian_hit_or_miss_integrator_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic void build_exp_points();
      longint unsigned hq, term, r, v;
      longint          sum;
      hq   = (64'd16 << 32) / 256;
      term = 64'd1 << 32;
      sum  = longint'(term);
      for (int n = 1; n <= 24; n++) begin
         term = ((term * hq) >> 32) / n;
         if (n & 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      r = longint'(sum);
      v = 64'd1 << 32;
      for (int k = 0; k <= 256; k++) begin
         if (k > 0) v = (v * r + 64'h8000_0000) >> 32;
         exp_points[k] = 32'((v + 64'h8000) >> 16);
      end
   endfunction

   function automatic longint unsigned exp_neg_q16(input longint unsigned t);
      longint unsigned unit, pos, idx, rem, a, b;
      unit = 64'd16 << 16;
      pos  = t * 256;
      idx  = pos / unit;
      rem  = pos % unit;
      if (idx >= 256) return 0;
      a = exp_points[idx];
      b = exp_points[idx + 1];
      return a - ((a - b) * rem) / unit;
   endfunction

   // Advance the counters by one sample; queue the estimate when it closes a run.
   function automatic void integrate_sample(input logic [15:0] ux, input logic [15:0] uy,
                                            input logic fin);
      longint          span, p, x, area;
      longint unsigned ax, t, e, h, s, q, mag, a;
      estimate_type    est;
      span = upper_q16 - lower_q16;
      p    = span * longint'(ux);
      if (p >= 0) x = lower_q16 + p / 65535;
      else x = lower_q16 - longint'((longint'(-p) + 65534) / 65535);
      ax = x < 0 ? -x : x;
      t  = (ax * ax) >> 17;
      e  = exp_neg_q16(t);
      if (sample_count < 64'hFFFF_FFFF) sample_count++;
      if (longint'(uy) * 65536 <= e * 65535 && hit_count < 64'hFFFF_FFFF) hit_count++;
      if (!fin) return;
      h = hit_count;
      s = sample_count;
      q = (h << 32) / s;
      mag = span < 0 ? -span : span;
      a = (mag * ghmi_pkg::F0_Q32) >> 24;
      area = longint'((a * q + (64'd1 << 39)) >> 40);
      if (span < 0) area = -area;
      est.area    = area[20:0];
      est.hits    = h[31:0];
      est.samples = s[31:0];
      estimate_q.push_back(est);
      hit_count    = 0;
      sample_count = 0;
   endfunction

   // valid stays up between beats of a burst; it drops only for a gap or an idle wait
   task automatic send_sample(input logic [15:0] ux, input logic [15:0] uy, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {uy, ux};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      integrate_sample(ux, uy, fin);
      samples_sent++;
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (estimate_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_bound(input logic [7:0] index, input longint value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[20:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == ghmi_pkg::CSR_LOWER) lower_q16 = longint'($signed(value[20:0]));
      else if (index == ghmi_pkg::CSR_UPPER) upper_q16 = longint'($signed(value[20:0]));
      @(posedge clock);
   endtask

   task automatic set_bounds(input longint lo, input longint hi);
      wait_idle();
      write_bound(ghmi_pkg::CSR_LOWER, lo);
      write_bound(ghmi_pkg::CSR_UPPER, hi);
      @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 16'h0000, 1'b0);
      send_sample(16'h0000, 16'hFFFF, 1'b1);
      send_sample(16'h8000, 16'h5555, 1'b1);
      send_sample(16'h7FFF, 16'hAAAA, 1'b1);
   endtask

   task automatic test_reversed_and_equal_bounds();
      set_bounds(65536 * 2, -65536 * 3);
      send_sample(16'h1234, 16'h4000, 1'b0);
      send_sample(16'hFFFF, 16'h0001, 1'b1);
      set_bounds(32768, 32768);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'h0000, 16'h0100, 1'b1);
      // span from -8.0 to just under 8.0 both ways, plus a register index the block must ignore
      set_bounds(-524288, 524287);
      write_bound(8'd7, 0);
      send_sample(16'hFFFF, 16'h0000, 1'b1);
      set_bounds(524287, -524288);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hC000, 16'h0000, 1'b1);
   endtask

   task automatic test_random_runs(input int total);
      int run_len;
      while (samples_sent < total) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: set_bounds(-65536 * 2, 65536 * 2);
               1: set_bounds(0, 65536);
               2: set_bounds(65536 * 3, -65536);
               default: set_bounds($urandom_range(0, 2097151) - 1048576,
                                    $urandom_range(0, 2097151) - 1048576);
            endcase
         end
         run_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
         for (int i = 0; i < run_len; i++)
            send_sample($urandom_range(0, 65535), $urandom_range(0, 65535), i == run_len - 1);
      end
   endtask

   // receiver stall pattern: no stalling, heavy stalling, or random ready about half the time
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 1) == 0);
         endcase
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[20:0], rsp_tdata[52:21], rsp_tdata[84:53]};
         estimates_seen++;
         if (estimate_q.size() == 0) begin
            report_mismatch("unexpected rsp beat, area", $signed(got.area), 0);
         end else begin
            want = estimate_q.pop_front();
            if (got.area != want.area)
               report_mismatch("area_estimate", $signed(got.area), $signed(want.area));
            if (got.hits != want.hits) report_mismatch("hits_total", got.hits, want.hits);
            if (got.samples != want.samples)
               report_mismatch("samples_total", got.samples, want.samples);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      burst_left = 0;
      lower_q16  = 0;
      upper_q16  = 65536;
      hit_count  = 0;
      sample_count = 0;
      build_exp_points();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_reversed_and_equal_bounds();
      set_bounds(-65536, 65536);
      test_random_runs(1400);
      // close any open run so no sample is left uncounted
      send_sample(16'h4000, 16'h2000, 1'b1);
      wait_idle();
      $display("Sent %0d samples, checked %0d estimates across several bound settings.",
               samples_sent, estimates_seen);
      if (error_count == 0 && estimate_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
